// ===== hdl/bdsl_pkg.sv =====
// Package for the button debounce and short/long press router.
// Holds the beat types, the per-button state record and the shared codes.
// No dependencies.
`default_nettype none
package bdsl_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int BTN_W = 2;
	localparam int PTR_W = 3;

	localparam logic [1:0] BTN_UP     = 2'd0;
	localparam logic [1:0] BTN_DOWN   = 2'd1;
	localparam logic [1:0] BTN_EXEC   = 2'd2;
	localparam logic [1:0] BTN_BRIGHT = 2'd3;

	localparam logic [1:0] LVL_PRESSED  = 2'd0;
	localparam logic [1:0] LVL_RELEASED = 2'd1;
	localparam logic [1:0] LVL_UNKNOWN  = 2'd2;

	localparam logic [2:0] ACT_MENU_UP   = 3'd0;
	localparam logic [2:0] ACT_MENU_DOWN = 3'd1;
	localparam logic [2:0] ACT_SELECT    = 3'd2;
	localparam logic [2:0] ACT_OPEN_MENU = 3'd3;
	localparam logic [2:0] ACT_HOST      = 3'd4;
	localparam logic [2:0] ACT_MODE      = 3'd5;
	localparam logic [2:0] ACT_BACKLIGHT = 3'd6;
	localparam logic [2:0] ACT_IGNORED   = 3'd7;

	localparam logic CFG_DEBOUNCE   = 1'b0;
	localparam logic CFG_LONG_PRESS = 1'b1;

	localparam logic [3:0]  DEBOUNCE_RESET   = 4'd2;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

	typedef struct packed {
		logic [3:0]  raw_levels;
		logic [31:0] now_ms;
		logic        menu_open;
		logic        host_active;
	} in_item_t;

	typedef struct packed {
		logic [1:0] button_id;
		logic       is_long;
		logic [2:0] action;
		logic [1:0] mode_index;
		logic [2:0] backlight_index;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  raw;
		logic [3:0]  run;
		logic [1:0]  trusted;
		logic [31:0] press_start;
		logic        long_done;
	} btn_state_t;

endpackage
`default_nettype wire

// ===== hdl/bdsl_step.sv =====
// Shared per-button step unit: debounce, edge handling, long press test and routing.
// Purely combinational; one button is handled per use. Depends on bdsl_pkg.
`default_nettype none
module bdsl_step #(
	parameter int LEVEL_COUNT = 5,
	parameter int MODE_COUNT = 3
) (
	input  wire logic [1:0]           btn_id,
	input  wire logic                 level,
	input  wire logic [31:0]          now_ms,
	input  wire logic                 menu_open,
	input  wire logic                 host_active,
	input  wire logic [3:0]           debounce_count,
	input  wire logic [15:0]          hold_limit,
	input  wire bdsl_pkg::btn_state_t cur,
	input  wire logic [1:0]           mode_sel,
	input  wire logic [2:0]           level_sel,
	output bdsl_pkg::btn_state_t      nxt,
	output logic [1:0]                mode_nxt,
	output logic [2:0]                level_nxt,
	output logic                      evt_valid,
	output bdsl_pkg::out_item_t       evt
);
	import bdsl_pkg::*;

	logic        chg;
	logic        press;
	logic        short_hit;
	logic        long_hit;
	logic [2:0]  short_act;
	logic [31:0] held;

	always_comb begin
		nxt = cur;
		if ({1'b0, level} == cur.raw) begin
			if (cur.run < debounce_count) begin
				nxt.run = cur.run + 4'd1;
			end
		end else begin
			nxt.raw = {1'b0, level};
			nxt.run = 4'd1;
		end

		chg = (nxt.run >= debounce_count) && (cur.trusted != nxt.raw);
		press = chg && (nxt.raw == LVL_PRESSED);
		short_hit = chg && (nxt.raw != LVL_PRESSED) && (cur.trusted == LVL_PRESSED) &&
			!cur.long_done;
		if (chg) begin
			nxt.trusted = nxt.raw;
		end
		if (press) begin
			nxt.press_start = now_ms;
			nxt.long_done = 1'b0;
		end

		mode_nxt = mode_sel;
		level_nxt = level_sel;
		short_act = ACT_IGNORED;
		if (menu_open) begin
			case (btn_id)
				BTN_UP:   short_act = ACT_MENU_UP;
				BTN_DOWN: short_act = ACT_MENU_DOWN;
				BTN_EXEC: short_act = ACT_SELECT;
				default:  short_act = ACT_IGNORED;
			endcase
		end else if (host_active) begin
			short_act = ACT_HOST;
		end else if (btn_id == BTN_UP) begin
			short_act = ACT_MODE;
			if (short_hit) begin
				mode_nxt = (mode_sel == 2'(MODE_COUNT - 1)) ? 2'd0 : mode_sel + 2'd1;
			end
		end else if (btn_id == BTN_DOWN) begin
			short_act = ACT_MODE;
			if (short_hit) begin
				mode_nxt = (mode_sel == 2'd0) ? 2'(MODE_COUNT - 1) : mode_sel - 2'd1;
			end
		end else begin
			short_act = ACT_BACKLIGHT;
			if (short_hit) begin
				level_nxt = (level_sel == 3'(LEVEL_COUNT - 1)) ? 3'd0 : level_sel + 3'd1;
			end
		end

		held = now_ms - nxt.press_start;
		long_hit = (btn_id == BTN_EXEC) && (nxt.trusted == LVL_PRESSED) && !nxt.long_done &&
			(held >= {16'd0, hold_limit});
		if (long_hit) begin
			nxt.long_done = 1'b1;
		end

		evt_valid = short_hit || long_hit;
		evt.button_id = btn_id;
		evt.is_long = long_hit;
		evt.action = long_hit ? ACT_OPEN_MENU : short_act;
		evt.mode_index = mode_nxt;
		evt.backlight_index = level_nxt;
		evt.last = 1'b0;
	end

endmodule
`default_nettype wire

// ===== hdl/bdsl_evt_queue.sv =====
// Event queue: collects the events of one poll in order and drains them as output beats.
// Marks the final beat of the poll. Depends on bdsl_pkg.
`default_nettype none
module bdsl_evt_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire bdsl_pkg::out_item_t push_data,
	input  wire logic                drain,
	input  wire logic                pop,
	input  wire logic                clear,
	output logic                     out_valid,
	output bdsl_pkg::out_item_t      out_data,
	output logic                     empty
);
	import bdsl_pkg::*;

	out_item_t        entry_q [NUM_BUTTONS];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (clear) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q[BTN_W-1:0]] <= push_data;
		end
	end

	always_comb begin
		empty = (rd_q == wr_q);
		out_valid = drain && !empty;
		out_data = entry_q[rd_q[BTN_W-1:0]];
		out_data.last = (rd_q + PTR_W'(1) == wr_q);
	end

endmodule
`default_nettype wire

// ===== hdl/button_debounce_short_long_router.sv =====
// Top level of the button debounce and short/long press router: sequencer and state.
// Uses bdsl_pkg, bdsl_step and bdsl_evt_queue.
//
//   port group            dir   beat contents
//   in_valid/in_ready     in    one poll: in_item_t
//   out_valid/out_ready   out   one routed event: out_item_t, last on the poll's final event
//   cfg_we/cfg_index      in    register write, cfg_wdata holds the value
//
// A poll is loaded, then walks the shared step unit one button at a time, then drains one
// event beat per cycle while out_ready is high, and ends in a closing cycle.
// The step unit and the single event queue read port set this pace.
// Reset restores all button state, the mode and backlight indexes and both registers.
// in_ready is low from acceptance through the closing cycle after the poll's last event beat.
`default_nettype none
module button_debounce_short_long_router #(
	parameter int LEVEL_COUNT = 5,
	parameter int MODE_COUNT = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bdsl_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bdsl_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [15:0]         cfg_wdata
);
	import bdsl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PROC = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [BTN_W-1:0] btn_q;
	in_item_t         item_q;
	logic [3:0]       debounce_q;
	logic [15:0]      long_press_q;
	btn_state_t       btn_st_q [NUM_BUTTONS];
	logic [1:0]       mode_q;
	logic [2:0]       level_q;

	btn_state_t nxt;
	logic [1:0] mode_nxt;
	logic [2:0] level_nxt;
	logic       evt_valid;
	out_item_t  evt;
	logic       q_empty;
	logic       q_clear;
	logic       in_fire;
	logic       out_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign q_clear = (state_q == S_EMIT) && q_empty;

	bdsl_step #(
		.LEVEL_COUNT(LEVEL_COUNT),
		.MODE_COUNT(MODE_COUNT)
	) u_step (
		.btn_id(btn_q),
		.level(item_q.raw_levels[btn_q]),
		.now_ms(item_q.now_ms),
		.menu_open(item_q.menu_open),
		.host_active(item_q.host_active),
		.debounce_count(debounce_q),
		.hold_limit(long_press_q),
		.cur(btn_st_q[btn_q]),
		.mode_sel(mode_q),
		.level_sel(level_q),
		.nxt(nxt),
		.mode_nxt(mode_nxt),
		.level_nxt(level_nxt),
		.evt_valid(evt_valid),
		.evt(evt)
	);

	bdsl_evt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push((state_q == S_PROC) && evt_valid),
		.push_data(evt),
		.drain(state_q == S_EMIT),
		.pop(out_fire),
		.clear(q_clear),
		.out_valid(out_valid),
		.out_data(out_data),
		.empty(q_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:   debounce_q <= cfg_wdata[3:0];
				CFG_LONG_PRESS: long_press_q <= cfg_wdata;
				default:        debounce_q <= debounce_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			btn_q <= '0;
			mode_q <= '0;
			level_q <= 3'(LEVEL_COUNT - 1);
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				btn_st_q[i] <= '{raw: LVL_UNKNOWN, run: 4'd0, trusted: LVL_UNKNOWN,
					press_start: 32'd0, long_done: 1'b0};
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_PROC;
						btn_q <= '0;
					end
				end
				S_PROC: begin
					btn_st_q[btn_q] <= nxt;
					mode_q <= mode_nxt;
					level_q <= level_nxt;
					if (btn_q == BTN_W'(NUM_BUTTONS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						btn_q <= btn_q + BTN_W'(1);
					end
				end
				S_EMIT: begin
					if (q_empty) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_EMIT))
		else $error("Output beat offered outside the emit phase.");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("Input ready while an event beat is pending.");
	a_proc_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROC && btn_q != BTN_W'(NUM_BUTTONS - 1)) |=>
		(state_q == S_PROC && btn_q == $past(btn_q) + BTN_W'(1)))
		else $error("Button walk skipped or left early.");
`endif

endmodule
`default_nettype wire
